>>> hdl/cipolla_pkg.sv
package cipolla_pkg;

  localparam int SEARCH_LIMIT = 256;

  localparam logic [0:0] REG_PRIME_MODULUS = 1'b0;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RED,
    ST_EPOW_INIT,
    ST_EPOW_MUL,
    ST_EPOW_SQR,
    ST_EPOW_CHK,
    ST_SRCH_INIT,
    ST_SRCH_SQ,
    ST_SRCH_POW_MUL,
    ST_SRCH_POW_SQR,
    ST_SRCH_CHK,
    ST_XP_INIT,
    ST_XP_M1,
    ST_XP_M2,
    ST_XP_M3,
    ST_XP_M4,
    ST_XP_M5,
    ST_XP_FIN,
    ST_FINAL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
  } mul_ctl_t;

endpackage

>>> hdl/modular_square_root_cipolla_core.sv
// Modular square root core, Cipolla's method.
// Input channel s_axis_*: tdata carries value_in. Output channel m_axis_*:
// tdata carries status, root_low, root_high, roots_equal.
// Configuration over APB: prime_modulus at address 0, to be written only while idle.
// One item at a time: s_axis_tready is high only when the core is idle
// and no result is waiting. Every modular multiply runs on one shared
// shift-and-add unit. The search for a quadratic non-residue tries at
// most 256 candidates, and reduction of the input is done by restoring
// subtraction. The result is held in an output register until
// m_axis_tready; the core stays busy meanwhile. Reset returns to idle,
// drops any item in flight and sets the modulus to 1000000007.
module modular_square_root_cipolla_core #(
  parameter int MODULUS_BITS = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // value_in[30:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // status, root_low, root_high, roots_equal
);

  localparam int W  = MODULUS_BITS;
  localparam int SW = 9;
  localparam logic [W-1:0] ONE = W'(1);

  typedef cipolla_pkg::state_t st_t;

  st_t state;

  logic [30:0]   modulus;
  logic [W-1:0]  p;
  logic [W-1:0]  a, t, c;
  logic [W:0]    rem;
  logic [W-1:0]  vin;
  logic [5:0]    bcnt;
  logic [W-1:0]  ex;
  logic [W-1:0]  pb, pacc;
  logic [W-1:0]  ar, ai, br, bi, tmp1, tmp2;
  logic [SW-1:0] k;
  logic [W-1:0]  mx, my;
  logic [W-1:0]  prod;
  logic          mdone;
  cipolla_pkg::mul_ctl_t mctl;
  logic          issue;
  logic          o_status, o_eq;
  logic [W-1:0]  o_lo, o_hi;
  logic          phase;
  logic [W-1:0]  half_m1, half_p1;
  logic [W:0]    sum;
  logic [W-1:0]  pm_x, x_lo, x_hi;
  logic [W-1:0]  one_m;

  assign p       = W'(modulus);
  assign pready  = 1'b1;
  assign prdata  = {1'b0, modulus};
  assign half_m1 = (p - ONE) >> 1;
  assign half_p1 = W'(({1'b0, p} + 1'b1) >> 1);
  assign one_m   = (p == ONE) ? '0 : ONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= 31'd1000000007;
    end else if (psel && penable && pwrite && paddr == cipolla_pkg::REG_PRIME_MODULUS) begin
      modulus <= 31'(pwdata[W-1:0]);
    end
  end

  assign mctl.start = issue;

  cipolla_mulmod #(.W(W)) u_mul (
    .clk(clk), .rst(rst), .ctl_in(mctl), .x(mx), .y(my), .m(p),
    .prod(prod), .done(mdone)
  );

  assign s_axis_tready = (state == cipolla_pkg::ST_IDLE) && !m_axis_tvalid;
  assign sum = {1'b0, tmp1} + {1'b0, prod};
  assign pm_x = (ar == '0) ? '0 : p - ar;
  assign x_lo = (ar < pm_x) ? ar : pm_x;
  assign x_hi = (ar < pm_x) ? pm_x : ar;

  always_comb begin
    issue = 1'b0;
    mx = '0;
    my = '0;
    unique case (state)
      cipolla_pkg::ST_IDLE: ;
      cipolla_pkg::ST_RED: ;
      cipolla_pkg::ST_EPOW_INIT, cipolla_pkg::ST_SRCH_INIT, cipolla_pkg::ST_XP_INIT,
      cipolla_pkg::ST_XP_FIN, cipolla_pkg::ST_FINAL, cipolla_pkg::ST_OUT: ;
      cipolla_pkg::ST_EPOW_MUL, cipolla_pkg::ST_SRCH_POW_MUL: begin
        mx = pacc; my = pb; issue = !phase && ex[0];
      end
      cipolla_pkg::ST_EPOW_SQR, cipolla_pkg::ST_SRCH_POW_SQR: begin
        mx = pb; my = pb; issue = !phase;
      end
      cipolla_pkg::ST_SRCH_SQ: begin mx = t; my = t; issue = !phase; end
      cipolla_pkg::ST_EPOW_CHK, cipolla_pkg::ST_SRCH_CHK: ;
      cipolla_pkg::ST_XP_M1: begin
        mx = ex[0] ? ar : br; my = ex[0] ? br : br; issue = !phase;
      end
      cipolla_pkg::ST_XP_M2: begin
        mx = ex[0] ? ai : bi; my = ex[0] ? bi : bi; issue = !phase;
      end
      cipolla_pkg::ST_XP_M3: begin mx = tmp2; my = c; issue = !phase; end
      cipolla_pkg::ST_XP_M4: begin
        mx = ex[0] ? ar : br; my = bi; issue = !phase;
      end
      cipolla_pkg::ST_XP_M5: begin
        mx = ex[0] ? ai : bi; my = br; issue = !phase;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cipolla_pkg::ST_IDLE;
      m_axis_tvalid <= 1'b0;
      phase <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (issue) phase <= 1'b1;
      if (mdone) phase <= 1'b0;
      unique case (state)
        cipolla_pkg::ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            vin  <= s_axis_tdata[W-1:0];
            rem  <= '0;
            bcnt <= 6'(W);
            o_status <= 1'b1; o_lo <= '0; o_hi <= '0; o_eq <= 1'b0;
            state <= (p == '0) ? cipolla_pkg::ST_OUT : cipolla_pkg::ST_RED;
          end
        end
        cipolla_pkg::ST_RED: begin
          if (bcnt != '0) begin
            if ({rem[W-1:0], vin[W-1]} >= {1'b0, p})
              rem <= {rem[W-1:0], vin[W-1]} - {1'b0, p};
            else
              rem <= {rem[W-1:0], vin[W-1]};
            vin  <= vin << 1;
            bcnt <= bcnt - 1'b1;
          end else begin
            a <= rem[W-1:0];
            if (rem[W-1:0] == '0) begin
              o_status <= 1'b0; o_eq <= 1'b1;
              state <= cipolla_pkg::ST_OUT;
            end else begin
              state <= cipolla_pkg::ST_EPOW_INIT;
            end
          end
        end
        cipolla_pkg::ST_EPOW_INIT: begin
          pacc <= one_m; pb <= a; ex <= half_m1;
          state <= (half_m1 == '0) ? cipolla_pkg::ST_EPOW_CHK : cipolla_pkg::ST_EPOW_MUL;
        end
        cipolla_pkg::ST_EPOW_MUL: begin
          if (!ex[0]) state <= cipolla_pkg::ST_EPOW_SQR;
          else if (mdone) begin pacc <= prod; state <= cipolla_pkg::ST_EPOW_SQR; end
        end
        cipolla_pkg::ST_EPOW_SQR: begin
          if (mdone) begin
            pb <= prod; ex <= ex >> 1;
            state <= (ex[W-1:1] == '0) ? cipolla_pkg::ST_EPOW_CHK
                                       : cipolla_pkg::ST_EPOW_MUL;
          end
        end
        cipolla_pkg::ST_EPOW_CHK: begin
          if (pacc != one_m || p == ONE) state <= cipolla_pkg::ST_OUT;
          else begin k <= SW'(1); t <= ONE; state <= cipolla_pkg::ST_SRCH_INIT; end
        end
        cipolla_pkg::ST_SRCH_INIT: state <= cipolla_pkg::ST_SRCH_SQ;
        cipolla_pkg::ST_SRCH_SQ: begin
          if (mdone) begin
            c <= (prod >= a) ? prod - a : W'({1'b0, prod} + {1'b0, p} - {1'b0, a});
            pacc <= one_m;
            pb <= (prod >= a) ? prod - a : W'({1'b0, prod} + {1'b0, p} - {1'b0, a});
            ex <= half_m1;
            state <= (half_m1 == '0) ? cipolla_pkg::ST_SRCH_CHK
                                     : cipolla_pkg::ST_SRCH_POW_MUL;
          end
        end
        cipolla_pkg::ST_SRCH_POW_MUL: begin
          if (!ex[0]) state <= cipolla_pkg::ST_SRCH_POW_SQR;
          else if (mdone) begin pacc <= prod; state <= cipolla_pkg::ST_SRCH_POW_SQR; end
        end
        cipolla_pkg::ST_SRCH_POW_SQR: begin
          if (mdone) begin
            pb <= prod; ex <= ex >> 1;
            state <= (ex[W-1:1] == '0) ? cipolla_pkg::ST_SRCH_CHK
                                       : cipolla_pkg::ST_SRCH_POW_MUL;
          end
        end
        cipolla_pkg::ST_SRCH_CHK: begin
          if (pacc == p - ONE) state <= cipolla_pkg::ST_XP_INIT;
          else if ({{(32-SW){1'b0}}, k} >= 32'(p) || k == SW'(cipolla_pkg::SEARCH_LIMIT))
            state <= cipolla_pkg::ST_OUT;
          else begin
            k <= k + 1'b1;
            t <= (t + ONE == p) ? '0 : t + ONE;
            state <= cipolla_pkg::ST_SRCH_SQ;
          end
        end
        cipolla_pkg::ST_XP_INIT: begin
          ar <= one_m; ai <= '0; br <= t; bi <= one_m; ex <= half_p1;
          state <= cipolla_pkg::ST_XP_M1;
        end
        cipolla_pkg::ST_XP_M1: if (mdone) begin tmp1 <= prod; state <= cipolla_pkg::ST_XP_M2; end
        cipolla_pkg::ST_XP_M2: if (mdone) begin tmp2 <= prod; state <= cipolla_pkg::ST_XP_M3; end
        cipolla_pkg::ST_XP_M3: begin
          // new real part waits in tmp2 until the imaginary part is done
          if (mdone) begin
            tmp2 <= (sum >= {1'b0, p}) ? W'(sum - {1'b0, p}) : sum[W-1:0];
            state <= cipolla_pkg::ST_XP_M4;
          end
        end
        cipolla_pkg::ST_XP_M4: begin
          if (mdone) begin tmp1 <= prod; state <= cipolla_pkg::ST_XP_M5; end
        end
        cipolla_pkg::ST_XP_M5: begin
          if (mdone) begin
            if (ex[0]) begin
              ai <= (sum >= {1'b0, p}) ? W'(sum - {1'b0, p}) : sum[W-1:0];
              ar <= tmp2;
            end else begin
              bi <= (sum >= {1'b0, p}) ? W'(sum - {1'b0, p}) : sum[W-1:0];
              br <= tmp2;
            end
            state <= cipolla_pkg::ST_XP_FIN;
          end
        end
        cipolla_pkg::ST_XP_FIN: begin
          if (ex[0]) ex[0] <= 1'b0;
          else ex <= ex >> 1;
          state <= (ex[0] || ex[W-1:1] != '0) ? cipolla_pkg::ST_XP_M1
                                              : cipolla_pkg::ST_FINAL;
        end
        cipolla_pkg::ST_FINAL: begin
          o_status <= 1'b0; o_lo <= x_lo; o_hi <= x_hi; o_eq <= (x_lo == x_hi);
          state <= cipolla_pkg::ST_OUT;
        end
        cipolla_pkg::ST_OUT: begin
          m_axis_tvalid <= 1'b1;
          state <= cipolla_pkg::ST_IDLE;
        end
        default: state <= cipolla_pkg::ST_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {o_eq, 31'(o_hi), 31'(o_lo), o_status};

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid) else $error("ready with result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_nores_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[62:1] == '0)
    else $error("no-root item carries roots");

endmodule

>>> hdl/cipolla_mulmod.sv
module cipolla_mulmod #(
  parameter int W = 31
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cipolla_pkg::mul_ctl_t ctl_in,
  input  logic [W-1:0]         x,
  input  logic [W-1:0]         y,
  input  logic [W-1:0]         m,
  output logic [W-1:0]         prod,
  output logic                 done
);

  localparam int CW = $clog2(W + 1);

  logic [W:0]    acc;
  logic [W-1:0]  xr;
  logic [W-1:0]  yr;
  logic [CW-1:0] cnt;
  logic          run;
  logic [W+1:0]  dbl;
  logic [W+1:0]  dbl_r;
  logic [W+1:0]  add;
  logic [W+1:0]  add_r;

  always_comb begin
    dbl   = {1'b0, acc} << 1;
    dbl_r = (dbl >= {2'b00, m}) ? dbl - {2'b00, m} : dbl;
    add   = dbl_r + (yr[W-1] ? {2'b00, xr} : '0);
    add_r = (add >= {2'b00, m}) ? add - {2'b00, m} : add;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl_in.start) begin
        run <= 1'b1;
        cnt <= CW'(W);
        acc <= '0;
        xr  <= x;
        yr  <= y;
      end else if (run) begin
        acc <= add_r[W:0];
        yr  <= yr << 1;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = acc[W-1:0];

endmodule

>>> tb/modular_square_root_cipolla_core_tb.sv
module modular_square_root_cipolla_core_tb;

  localparam int WIDTH = 31;
  localparam longint unsigned WMASK = (64'd1 << WIDTH) - 1;
  localparam int SEARCH_MAX = 256;
  localparam int STALL_LIMIT = 3000000;

  typedef struct packed {
    logic        roots_equal;
    logic [30:0] root_high;
    logic [30:0] root_low;
    logic        status;
  } root_item_t;

  class sqrt_scoreboard;
    longint unsigned modulus;
    root_item_t pending[$];
    int errors;

    function new();
      modulus = 64'd1000000007;
      errors = 0;
    endfunction

    function longint unsigned mulm(longint unsigned x, longint unsigned y,
                                   longint unsigned m);
      return (x * y) % m;
    endfunction

    function longint unsigned powm(longint unsigned b, longint unsigned e,
                                   longint unsigned m);
      longint unsigned acc;
      acc = 1 % m;
      b = b % m;
      while (e != 0) begin
        if (e[0]) acc = mulm(acc, b, m);
        b = mulm(b, b, m);
        e = e >> 1;
      end
      return acc;
    endfunction

    // real part of (re + w)^e in GF(m^2), w^2 = sq
    function longint unsigned ext_real(longint unsigned re, longint unsigned e,
                                       longint unsigned sq, longint unsigned m);
      longint unsigned ar, ai, br, bi, nr, ni;
      ar = 1 % m;
      ai = 0;
      br = re % m;
      bi = 1 % m;
      while (e != 0) begin
        if (e[0]) begin
          nr = (mulm(ar, br, m) + mulm(mulm(ai, bi, m), sq, m)) % m;
          ni = (mulm(ar, bi, m) + mulm(ai, br, m)) % m;
          ar = nr;
          ai = ni;
        end
        nr = (mulm(br, br, m) + mulm(mulm(bi, bi, m), sq, m)) % m;
        ni = (mulm(br, bi, m) + mulm(bi, br, m)) % m;
        br = nr;
        bi = ni;
        e = e >> 1;
      end
      return ar;
    endfunction

    function root_item_t square_roots(longint unsigned v);
      root_item_t r;
      longint unsigned p, a, k, t, c, x, lo, hi;
      bit found;
      p = modulus;
      r = '0;
      r.status = 1'b1;
      found = 0;
      t = 0;
      c = 0;
      if (p == 0) return r;
      a = (v & WMASK) % p;
      if (a == 0) begin
        r.status = 1'b0;
        r.roots_equal = 1'b1;
        return r;
      end
      if (powm(a, (p - 1) / 2, p) != 1 % p || p == 1) return r;
      for (k = 1; k <= p && k <= SEARCH_MAX; k++) begin
        t = k % p;
        c = (mulm(t, t, p) + p - a) % p;
        if (powm(c, (p - 1) / 2, p) == p - 1) begin
          found = 1;
          break;
        end
      end
      if (!found) return r;
      x = ext_real(t, (p + 1) / 2, c, p);
      lo = x;
      hi = (p - x) % p;
      if (lo > hi) begin
        lo = hi;
        hi = x;
      end
      r.status = 1'b0;
      r.root_low = lo[30:0];
      r.root_high = hi[30:0];
      r.roots_equal = (lo == hi);
      return r;
    endfunction

    function void note_value(longint unsigned v);
      pending = {pending, square_roots(v)};
    endfunction

    function void check_roots(logic [63:0] data);
      root_item_t got, exp_r;
      got = data;
      if (pending.size() == 0) begin
        $error("result with no item pending: %h", data);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.status !== exp_r.status) begin
        $error("status exp %0d got %0d", exp_r.status, got.status);
        errors++;
      end
      if (got.root_low !== exp_r.root_low) begin
        $error("root_low exp %0d got %0d", exp_r.root_low, got.root_low);
        errors++;
      end
      if (got.root_high !== exp_r.root_high) begin
        $error("root_high exp %0d got %0d", exp_r.root_high, got.root_high);
        errors++;
      end
      if (got.roots_equal !== exp_r.roots_equal) begin
        $error("roots_equal exp %0d got %0d", exp_r.roots_equal, got.roots_equal);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [0:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic s_axis_tvalid, s_axis_tready;
  logic [31:0] s_axis_tdata;   // value_in[30:0]
  logic m_axis_tvalid, m_axis_tready;
  logic [63:0] m_axis_tdata;   // status, root_low, root_high, roots_equal

  sqrt_scoreboard sb;
  int send_idle_pct, recv_idle_pct;
  int stall_count;

  modular_square_root_cipolla_core uut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  task automatic write_modulus(longint unsigned p);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= cipolla_pkg::REG_PRIME_MODULUS; pwdata <= p[31:0];
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.modulus = p & WMASK;
  endtask

  task automatic send_value(longint unsigned v);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {1'b0, v[30:0]};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_value(v & WMASK);
  endtask

  task automatic drain;
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic longint unsigned pick_value();
    longint unsigned p, r;
    int sel;
    p = sb.modulus;
    sel = $urandom_range(99);
    if (p < 2) return $urandom() & WMASK;
    r = $urandom_range(p - 1);
    if (sel < 8) return 0;
    if (sel < 14) return p * $urandom_range(1, WMASK / p);
    if (sel < 30) return $urandom() & WMASK;
    if (sel < 60) return (r * r) % p;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) sb.check_roots(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_count <= 0;
    else
      stall_count <= stall_count + 1;
    if (stall_count > STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    longint unsigned moduli[] = '{3, 5, 7, 13, 97, 7919, 65537, 104729,
                                  998244353, 1000000007, 2147483647};
    longint unsigned odd_moduli[] = '{0, 1, 2, 9, 15, 2147483647};
    longint unsigned p;
    int sent;
    sb = new();
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    s_axis_tvalid = 0; s_axis_tdata = '0;
    send_idle_pct = 14;
    recv_idle_pct = 69;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset modulus: edges of the value range
    send_value(0);
    send_value(1);
    send_value(4);
    send_value(1000000006);
    send_value(1000000007);
    send_value(1000000008);
    send_value(5);
    send_value(WMASK);
    send_value(64'h2AAAAAAA);
    send_value(64'h55555555 & WMASK);
    drain();

    // degenerate and composite moduli, plus the primes 2 and 2147483647
    foreach (odd_moduli[i]) begin
      write_modulus(odd_moduli[i]);
      send_value(0);
      send_value(1);
      send_value(4);
      send_value(odd_moduli[i] == 0 ? 3 : odd_moduli[i] - 1);
      drain();
    end

    sent = 0;
    while (sent < 1500) begin
      p = moduli[$urandom_range(moduli.size() - 1)];
      write_modulus(p);
      repeat (40) begin
        if (sent < 500) begin
          send_idle_pct = 14; recv_idle_pct = 69;
        end else if (sent < 1000) begin
          send_idle_pct = 69; recv_idle_pct = 14;
        end else begin
          send_idle_pct = 0; recv_idle_pct = 0;
        end
        send_value(pick_value());
        sent++;
      end
      drain();
    end

    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
